/* src/assert_macros.svh */
// Assertion macros used by the allocator datapath (hbba_dp).
// They expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("invariant check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`endif
`endif

/* src/hbba_pkg.sv */
// ----------------------------------------------------------------------------
// hbba_pkg
// Types and constants shared by the bitmap block allocator modules.
// ----------------------------------------------------------------------------
package hbba_pkg;

    localparam int WORD_BITS = 64;
    localparam int BLK_W     = 20;
    localparam int CFG_W     = 15;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_Q_RD,
        ST_Q_LD,
        ST_F_DIV_G,
        ST_F_DIV_T,
        ST_F_RD,
        ST_F_WR,
        ST_A_TOP,
        ST_A_MRD,
        ST_A_MLD,
        ST_A_GSEL,
        ST_A_LBASE,
        ST_A_LCHK,
        ST_A_LLD,
        ST_A_MARK,
        ST_A_GFCHK,
        ST_A_GFLD,
        ST_A_MSET,
        ST_A_TFCHK,
        ST_A_TFLD
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    clr_step;
        logic    rd_blk;
        logic    div_g;
        logic    div_t;
        logic    free_wr;
        logic    top_init;
        logic    top_next;
        logic    top_set;
        logic    mgrp_init;
        logic    rem_calc;
        logic    mid_load;
        logic    mid_next;
        logic    g_pick;
        logic    lbase;
        logic    low_next;
        logic    low_load;
        logic    mark;
        logic    mset;
        logic    tscan_next;
        logic    resp;
        status_t resp_status;
        logic    resp_grant;
        logic    resp_query;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       out_of_range;
        logic       clr_last;
        logic       top_end;
        logic       top_bit;
        logic       mid_last;
        logic       avail_zero;
        logic       low_end;
        logic       low_full;
        logic       gf_end;
        logic       mid_end;
        logic       mid_padded_full;
    } dp_status_t;

endpackage

/* src/hbba_ram.sv */
// ----------------------------------------------------------------------------
// hbba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hbba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/hbba_dp.sv */
// ----------------------------------------------------------------------------
// hbba_dp
// Datapath: bitmap memories, top map flops, scan counters and result
// registers, all steered by the controller's command word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbba_dp import hbba_pkg::*; #(
    parameter int LOW_WORDS   = 16384,
    parameter int GROUP_WORDS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic [1:0]       req_type,
    input  logic [BLK_W-1:0] block_number,
    input  dp_cmd_t          cmd,
    output dp_status_t       stat,
    output logic [BLK_W-1:0] granted_block,
    output logic [1:0]       status,
    output logic             in_use,
    output logic             done
);

    localparam int LA_W      = $clog2(LOW_WORDS);
    localparam int MID_BITS  = (LOW_WORDS + GROUP_WORDS - 1) / GROUP_WORDS;
    localparam int MID_WORDS = (MID_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int TOP_BITS  = (MID_WORDS + GROUP_WORDS - 1) / GROUP_WORDS;
    localparam int MA_W      = (MID_WORDS > 1) ? $clog2(MID_WORDS) : 1;
    localparam int MWC_W     = $clog2(MID_WORDS + 1);
    localparam int G_W       = $clog2(MID_BITS);
    localparam int T_W       = $clog2(TOP_BITS + 1);
    localparam int LWC_W     = $clog2(LOW_WORDS + GROUP_WORDS + 1);
    localparam int CNT_W     = $clog2(GROUP_WORDS + 1);
    localparam int WIU_W     = $clog2(LOW_WORDS + 1);
    localparam int LOW_SPAN  = WORD_BITS * GROUP_WORDS;
    localparam int DIV_L     = $clog2(GROUP_WORDS);
    localparam int DIV_S     = LA_W + DIV_L;
    localparam int PROD_W    = 2 * LA_W + 2;
    localparam logic [PROD_W-1:0] DIV_M =
        PROD_W'(((longint'(1) << DIV_S) + GROUP_WORDS - 1) / GROUP_WORDS);
    localparam int PAD_SH    = MID_BITS - (MID_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] PAD_LAST =
        (PAD_SH >= WORD_BITS) ? '0 : ({WORD_BITS{1'b1}} << PAD_SH);

    logic [WIU_W-1:0]     wiu_reg;
    logic [1:0]           req_reg;
    logic [BLK_W-1:0]     blk_reg;
    logic [LA_W-1:0]      clr_reg;
    logic [T_W-1:0]       t_reg;
    logic [MWC_W-1:0]     mw_reg;
    logic [CNT_W-1:0]     mcnt_reg;
    logic [CNT_W-1:0]     icnt_reg;
    logic [WIU_W-1:0]     rem_reg;
    logic [WORD_BITS-1:0] midw_reg;
    logic [WORD_BITS-1:0] avail_reg;
    logic [G_W-1:0]       g_reg;
    logic [LWC_W-1:0]     lw_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [BLK_W-1:0]     found_reg;
    logic [TOP_BITS-1:0]  top_reg;
    logic [BLK_W-1:0]     granted_reg;
    logic [1:0]           status_reg;
    logic                 in_use_reg;
    logic                 done_reg;

    logic [LA_W-1:0]      blk_la;
    logic                 low_we;
    logic [LA_W-1:0]      low_waddr;
    logic [LA_W-1:0]      low_raddr;
    logic [WORD_BITS-1:0] low_wdata;
    logic [WORD_BITS-1:0] low_rdata;
    logic                 mid_we;
    logic [MA_W-1:0]      mid_waddr;
    logic [WORD_BITS-1:0] mid_wdata;
    logic [WORD_BITS-1:0] mid_rdata;
    logic [WORD_BITS-1:0] gbit;
    logic [WORD_BITS-1:0] zbit;
    logic [5:0]           zero_off;
    logic [5:0]           pick_b;
    logic [MWC_W-1:0]     mw_from_g;
    logic [LA_W-1:0]      div_x;
    logic [PROD_W-1:0]    div_prod;
    logic [PROD_W-1:0]    div_q;
    logic [WIU_W-1:0]     rem_next;
    logic [WORD_BITS-1:0] elig;
    logic [WORD_BITS-1:0] mid_pad;
    logic                 top_bit;
    int                   rem_base;

    function automatic logic [5:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [5:0] n;
        n = 6'd63;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] first_one(input logic [WORD_BITS-1:0] w);
        logic [5:0] n;
        n = 6'd0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

    assign blk_la    = LA_W'(blk_reg[19:6]);
    assign zero_off  = first_zero(word_reg);
    assign zbit      = WORD_BITS'(1) << zero_off;
    assign gbit      = WORD_BITS'(1) << 6'(g_reg);
    assign pick_b    = first_one(avail_reg);
    assign mw_from_g = MWC_W'(32'(g_reg) >> 6);

    // Floor division by the group size as a multiply by a rounded-up reciprocal.
    assign div_x    = cmd.div_t ? LA_W'(mw_from_g) : blk_la;
    assign div_prod = PROD_W'(div_x) * DIV_M;
    assign div_q    = div_prod >> DIV_S;

    assign rem_base = 32'(mw_reg) * LOW_SPAN;
    assign rem_next = (32'(wiu_reg) > rem_base) ? WIU_W'(32'(wiu_reg) - rem_base) : '0;

    // A group is searchable only if its first low word lies below the word count.
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            elig[b] = (b * GROUP_WORDS) < 32'(rem_reg);
        end
    end

    always_comb
    begin
        top_bit = 1'b0;
        for (int k = 0; k < TOP_BITS; k++)
        begin
            if (32'(t_reg) == k)
            begin
                top_bit = top_reg[k];
            end
        end
    end

    assign mid_pad = (32'(mw_reg) == MID_WORDS - 1) ? PAD_LAST : '0;

    assign low_we    = cmd.clr_step | cmd.free_wr | cmd.mark;
    assign low_waddr = cmd.clr_step ? clr_reg : (cmd.free_wr ? blk_la : lw_reg[LA_W-1:0]);
    assign low_raddr = cmd.rd_blk ? blk_la : lw_reg[LA_W-1:0];

    always_comb
    begin
        if (cmd.clr_step)
        begin
            low_wdata = '0;
        end
        else if (cmd.free_wr)
        begin
            low_wdata = low_rdata & ~(WORD_BITS'(1) << blk_reg[5:0]);
        end
        else
        begin
            low_wdata = word_reg | zbit;
        end
    end

    assign mid_we    = (cmd.clr_step && (32'(clr_reg) < MID_WORDS)) | cmd.free_wr | cmd.mset;
    assign mid_waddr = cmd.clr_step ? MA_W'(clr_reg) : mw_reg[MA_W-1:0];

    always_comb
    begin
        if (cmd.clr_step)
        begin
            mid_wdata = '0;
        end
        else if (cmd.free_wr)
        begin
            mid_wdata = mid_rdata & ~gbit;
        end
        else
        begin
            mid_wdata = midw_reg | gbit;
        end
    end

    hbba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (LOW_WORDS)
    ) u_low_ram (
        .clk   (clk),
        .we    (low_we),
        .waddr (low_waddr),
        .wdata (low_wdata),
        .raddr (low_raddr),
        .rdata (low_rdata)
    );

    hbba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MID_WORDS)
    ) u_mid_ram (
        .clk   (clk),
        .we    (mid_we),
        .waddr (mid_waddr),
        .wdata (mid_wdata),
        .raddr (mw_reg[MA_W-1:0]),
        .rdata (mid_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wiu_reg  <= WIU_W'(LOW_WORDS);
            clr_reg  <= '0;
            top_reg  <= '0;
            t_reg    <= '0;
            icnt_reg <= '0;
            mcnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                wiu_reg <= (32'(cfg_data) > LOW_WORDS) ? WIU_W'(LOW_WORDS)
                                                        : WIU_W'(cfg_data);
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.top_init)
            begin
                t_reg <= '0;
            end
            else if (cmd.top_next)
            begin
                t_reg <= t_reg + 1'b1;
            end
            else if (cmd.div_t)
            begin
                t_reg <= T_W'(div_q);
            end
            for (int k = 0; k < TOP_BITS; k++)
            begin
                if (32'(t_reg) == k)
                begin
                    if (cmd.top_set)
                    begin
                        top_reg[k] <= 1'b1;
                    end
                    else if (cmd.free_wr)
                    begin
                        top_reg[k] <= 1'b0;
                    end
                end
            end
            if (cmd.mgrp_init)
            begin
                mcnt_reg <= '0;
            end
            else if (cmd.mid_next)
            begin
                mcnt_reg <= mcnt_reg + 1'b1;
            end
            if (cmd.lbase || cmd.mset)
            begin
                icnt_reg <= '0;
            end
            else if (cmd.low_next || cmd.tscan_next)
            begin
                icnt_reg <= icnt_reg + 1'b1;
            end
            done_reg <= cmd.resp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_type;
            blk_reg <= block_number;
        end
        if (cmd.mgrp_init || cmd.mset)
        begin
            mw_reg <= MWC_W'(32'(t_reg) * GROUP_WORDS);
        end
        else if (cmd.mid_next || cmd.tscan_next)
        begin
            mw_reg <= mw_reg + 1'b1;
        end
        else if (cmd.div_t)
        begin
            mw_reg <= mw_from_g;
        end
        if (cmd.rem_calc)
        begin
            rem_reg <= rem_next;
        end
        if (cmd.mid_load)
        begin
            midw_reg  <= mid_rdata;
            avail_reg <= ~mid_rdata & elig;
        end
        else if (cmd.g_pick)
        begin
            avail_reg[pick_b] <= 1'b0;
        end
        if (cmd.g_pick)
        begin
            g_reg <= G_W'({mw_reg[MA_W-1:0], pick_b});
        end
        else if (cmd.div_g)
        begin
            g_reg <= G_W'(div_q);
        end
        if (cmd.lbase)
        begin
            lw_reg <= LWC_W'(32'(g_reg) * GROUP_WORDS);
        end
        else if (cmd.low_next)
        begin
            lw_reg <= lw_reg + 1'b1;
        end
        if (cmd.low_load)
        begin
            word_reg <= low_rdata;
        end
        if (cmd.mark)
        begin
            found_reg <= BLK_W'({lw_reg, zero_off});
        end
        if (cmd.resp)
        begin
            status_reg  <= cmd.resp_status;
            granted_reg <= cmd.resp_grant ? found_reg : '0;
            in_use_reg  <= cmd.resp_query ? low_rdata[blk_reg[5:0]] : 1'b0;
        end
    end

    always_comb
    begin
        stat.req_type        = req_reg;
        stat.out_of_range    = 32'(blk_reg[19:6]) >= 32'(wiu_reg);
        stat.clr_last        = 32'(clr_reg) == LOW_WORDS - 1;
        stat.top_end         = 32'(t_reg) >= TOP_BITS;
        stat.top_bit         = top_bit;
        stat.mid_last        = (32'(mcnt_reg) == GROUP_WORDS - 1)
                               || (32'(mw_reg) + 1 >= MID_WORDS);
        stat.avail_zero      = avail_reg == '0;
        stat.low_end         = (32'(icnt_reg) == GROUP_WORDS)
                               || (32'(lw_reg) >= 32'(wiu_reg));
        stat.low_full        = low_rdata == '1;
        stat.gf_end          = (32'(icnt_reg) == GROUP_WORDS) || (32'(lw_reg) >= LOW_WORDS);
        stat.mid_end         = (32'(icnt_reg) == GROUP_WORDS) || (32'(mw_reg) >= MID_WORDS);
        stat.mid_padded_full = (mid_rdata | mid_pad) == '1;
    end

    assign granted_block = granted_reg;
    assign status        = status_reg;
    assign in_use        = in_use_reg;
    assign done          = done_reg;

    `ASSERT_ALWAYS(a_top_index_bound, clk, rst_n, 32'(t_reg) <= TOP_BITS)
    `ASSERT_ALWAYS(a_scan_count_bound, clk, rst_n, 32'(icnt_reg) <= GROUP_WORDS)
    `ASSERT_IMPLY(a_mark_not_full, clk, rst_n, cmd.mark, word_reg != '1)

endmodule

/* src/hbba_ctrl.sv */
// ----------------------------------------------------------------------------
// hbba_ctrl
// Controller: sequences the clearing pass and the allocate, free and
// query transactions over the datapath.
// ----------------------------------------------------------------------------
module hbba_ctrl import hbba_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t stat,
    output dp_cmd_t    cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.req_type)
                    REQ_ALLOC: state_next = ST_A_TOP;
                    REQ_FREE:  state_next = stat.out_of_range ? ST_IDLE : ST_F_DIV_G;
                    REQ_QUERY: state_next = stat.out_of_range ? ST_IDLE : ST_Q_RD;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_Q_RD:    state_next = ST_Q_LD;
            ST_Q_LD:    state_next = ST_IDLE;
            ST_F_DIV_G: state_next = ST_F_DIV_T;
            ST_F_DIV_T: state_next = ST_F_RD;
            ST_F_RD:    state_next = ST_F_WR;
            ST_F_WR:    state_next = ST_IDLE;
            ST_A_TOP:
            begin
                if (stat.top_end)
                begin
                    state_next = ST_IDLE;
                end
                else if (!stat.top_bit)
                begin
                    state_next = ST_A_MRD;
                end
            end
            ST_A_MRD:   state_next = ST_A_MLD;
            ST_A_MLD:   state_next = ST_A_GSEL;
            ST_A_GSEL:
            begin
                if (!stat.avail_zero)
                begin
                    state_next = ST_A_LBASE;
                end
                else if (stat.mid_last)
                begin
                    state_next = ST_A_TOP;
                end
                else
                begin
                    state_next = ST_A_MRD;
                end
            end
            ST_A_LBASE: state_next = ST_A_LCHK;
            ST_A_LCHK:  state_next = stat.low_end ? ST_A_GSEL : ST_A_LLD;
            ST_A_LLD:   state_next = stat.low_full ? ST_A_LCHK : ST_A_MARK;
            ST_A_MARK:  state_next = ST_A_GFCHK;
            ST_A_GFCHK: state_next = stat.gf_end ? ST_A_MSET : ST_A_GFLD;
            ST_A_GFLD:  state_next = stat.low_full ? ST_A_GFCHK : ST_IDLE;
            ST_A_MSET:  state_next = ST_A_TFCHK;
            ST_A_TFCHK: state_next = stat.mid_end ? ST_IDLE : ST_A_TFLD;
            ST_A_TFLD:  state_next = stat.mid_padded_full ? ST_A_TFCHK : ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.resp_status = STATUS_OK;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.capture = start;
            end
            ST_DECODE:
            begin
                case (stat.req_type)
                    REQ_ALLOC:
                    begin
                        cmd.top_init = 1'b1;
                    end
                    REQ_FREE, REQ_QUERY:
                    begin
                        if (stat.out_of_range)
                        begin
                            cmd.resp        = 1'b1;
                            cmd.resp_status = STATUS_RANGE;
                        end
                    end
                    default:
                    begin
                        cmd.resp = 1'b1;
                    end
                endcase
            end
            ST_Q_RD:
            begin
                cmd.rd_blk = 1'b1;
            end
            ST_Q_LD:
            begin
                cmd.resp       = 1'b1;
                cmd.resp_query = 1'b1;
            end
            ST_F_DIV_G:
            begin
                cmd.div_g = 1'b1;
            end
            ST_F_DIV_T:
            begin
                cmd.div_t = 1'b1;
            end
            ST_F_RD:
            begin
                cmd.rd_blk = 1'b1;
            end
            ST_F_WR:
            begin
                cmd.free_wr = 1'b1;
                cmd.resp    = 1'b1;
            end
            ST_A_TOP:
            begin
                if (stat.top_end)
                begin
                    cmd.resp        = 1'b1;
                    cmd.resp_status = STATUS_FULL;
                end
                else if (stat.top_bit)
                begin
                    cmd.top_next = 1'b1;
                end
                else
                begin
                    cmd.mgrp_init = 1'b1;
                end
            end
            ST_A_MRD:
            begin
                cmd.rem_calc = 1'b1;
            end
            ST_A_MLD:
            begin
                cmd.mid_load = 1'b1;
            end
            ST_A_GSEL:
            begin
                if (!stat.avail_zero)
                begin
                    cmd.g_pick = 1'b1;
                end
                else if (stat.mid_last)
                begin
                    cmd.top_next = 1'b1;
                end
                else
                begin
                    cmd.mid_next = 1'b1;
                end
            end
            ST_A_LBASE:
            begin
                cmd.lbase = 1'b1;
            end
            ST_A_LLD:
            begin
                if (stat.low_full)
                begin
                    cmd.low_next = 1'b1;
                end
                else
                begin
                    cmd.low_load = 1'b1;
                end
            end
            ST_A_MARK:
            begin
                // Write the claimed bit and rewind to the group's first word.
                cmd.mark  = 1'b1;
                cmd.lbase = 1'b1;
            end
            ST_A_GFLD:
            begin
                if (stat.low_full)
                begin
                    cmd.low_next = 1'b1;
                end
                else
                begin
                    cmd.resp       = 1'b1;
                    cmd.resp_grant = 1'b1;
                end
            end
            ST_A_MSET:
            begin
                cmd.mset = 1'b1;
            end
            ST_A_TFCHK:
            begin
                if (stat.mid_end)
                begin
                    cmd.top_set    = 1'b1;
                    cmd.resp       = 1'b1;
                    cmd.resp_grant = 1'b1;
                end
            end
            ST_A_TFLD:
            begin
                if (stat.mid_padded_full)
                begin
                    cmd.tscan_next = 1'b1;
                end
                else
                begin
                    cmd.resp       = 1'b1;
                    cmd.resp_grant = 1'b1;
                end
            end
            default:
            begin
                cmd.resp_status = STATUS_OK;
            end
        endcase
    end

endmodule

/* src/hierarchical_bitmap_block_allocator.sv */
// ----------------------------------------------------------------------------
// hierarchical_bitmap_block_allocator
// Three-level bitmap block allocator; one transaction at a time, and results cannot stall.
// Query reads the block's low word. Free finds the block's group and top bit, then clears
// its low, mid and top bits. An out-of-range free or query returns STATUS_RANGE; type 3 is
// a no-op. Allocate scans the top map for a clear bit, reads mid words for a free eligible
// group, scans its low words for a zero bit and marks it, then checks whether the group
// filled (setting its mid bit) and, if so, whether its mid group filled (setting its top bit).
// A new transaction is taken while done is high. After reset a clearing pass zeroes the low
// and mid maps with busy high.
module hierarchical_bitmap_block_allocator import hbba_pkg::*; #(
    parameter int LOW_WORDS   = 16384,
    parameter int GROUP_WORDS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       req_type,
    input  logic [BLK_W-1:0] block_number,
    input  logic             words_in_use_wr,
    input  logic [CFG_W-1:0] words_in_use,
    output logic             done,
    output logic [BLK_W-1:0] granted_block,
    output logic [1:0]       status,
    output logic             in_use
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    hbba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    hbba_dp #(
        .LOW_WORDS   (LOW_WORDS),
        .GROUP_WORDS (GROUP_WORDS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr        (words_in_use_wr),
        .cfg_data      (words_in_use),
        .req_type      (req_type),
        .block_number  (block_number),
        .cmd           (cmd),
        .stat          (stat),
        .granted_block (granted_block),
        .status        (status),
        .in_use        (in_use),
        .done          (done)
    );

endmodule
